@@ design/pcxrle_pkg.sv @@
// Shared types and constants of the PCX run-length line decoder.
`default_nettype none
package pcxrle_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned COL_W    = 15;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Marker detection
  localparam logic [BYTE_W-1:0]  MARK_BITS  = 8'hC0;
  localparam logic [COUNT_W-1:0] COUNT_MASK = 6'h3F;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 1'b1;

  // Register reset values
  localparam logic [COL_W-1:0] BPL_RESET   = 15'd320;
  localparam logic [ROW_W-1:0] LINES_RESET = 16'd200;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_run;   // latch the count of a marker byte
    logic emit;       // load one pixel into the output register
    logic sel_input;  // pixel value comes from the input word
    logic load_rem;   // latch value byte and remaining run count
    logic dec_rem;    // one more run pixel sent
    logic last;       // final pixel for the current input word
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_marker;  // input word has both top bits set
    logic cnt_zero;   // clipped run count is zero
    logic cnt_one;    // clipped run count is one
    logic rem_one;    // one run pixel left
    logic out_free;   // output register can take a pixel this cycle
    logic finished;   // image complete
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/pcxrle_ctrl.sv @@
// Controller state machine of the PCX run-length line decoder.
`default_nettype none
module pcxrle_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pcxrle_pkg::dp_stat_t stat,
  output pcxrle_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_CODE  = 2'd0;
  localparam logic [1:0] ST_VALUE = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       ready;
  logic       accept;

  // Take a word unless a run is draining or, before the image end, the output register is blocked
  assign ready    = (state_r != ST_RUN) && (stat.out_free || stat.finished);
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // Decode the next state and the datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CODE: begin
        if (accept && !stat.finished) begin
          if (stat.is_marker) begin
            cmd.load_run = 1'b1;
            state_nxt    = ST_VALUE;
          end else begin
            cmd.emit      = 1'b1;
            cmd.sel_input = 1'b1;
            cmd.last      = 1'b1;
          end
        end
      end
      ST_VALUE: begin
        if (accept && !stat.finished) begin
          state_nxt = ST_CODE;
          if (!stat.cnt_zero) begin
            cmd.emit      = 1'b1;
            cmd.sel_input = 1'b1;
            cmd.load_rem  = 1'b1;
            cmd.last      = stat.cnt_one;
            if (!stat.cnt_one) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.dec_rem = 1'b1;
          cmd.last    = stat.rem_one;
          if (stat.rem_one) begin
            state_nxt = ST_CODE;
          end
        end
      end
      default: begin
        state_nxt = ST_CODE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CODE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A draining run never takes a new word
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> in_stall)
    else $error("input taken during run");

  // A clipped run of two or more pixels continues in the run state
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (state_r == ST_VALUE) && !stat.finished && !stat.cnt_zero && !stat.cnt_one)
      |=> (state_r == ST_RUN))
    else $error("long run did not enter run state");

  // The run ends with a pixel flagged as last
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && (state_nxt == ST_CODE)) |-> (cmd.emit && cmd.last))
    else $error("run ended without last pixel");

endmodule
`default_nettype wire

@@ design/pcxrle_dp.sv @@
// Datapath of the PCX run-length line decoder: position, run and output registers.
`default_nettype none
module pcxrle_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  [pcxrle_pkg::BYTE_W-1:0]         in_code_byte,
  input  wire                                   cfg_we,
  input  wire  [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pcxrle_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                   out_stall,
  output logic                                  out_valid,
  output logic [pcxrle_pkg::BYTE_W-1:0]         out_pixel_value,
  output logic                                  out_line_end,
  output logic                                  out_image_end,
  output logic                                  out_last,
  input  pcxrle_pkg::ctrl_cmd_t                 cmd,
  output pcxrle_pkg::dp_stat_t                  stat
);

  localparam int unsigned BYTE_W  = pcxrle_pkg::BYTE_W;
  localparam int unsigned COUNT_W = pcxrle_pkg::COUNT_W;
  localparam int unsigned COL_W   = pcxrle_pkg::COL_W;
  localparam int unsigned ROW_W   = pcxrle_pkg::ROW_W;

  // Configuration
  logic [COL_W-1:0]   bpl_r;
  logic [ROW_W-1:0]   lines_r;
  // Decoding state
  logic [COUNT_W-1:0] run_len_r;
  logic [COUNT_W-1:0] rem_r;
  logic [BYTE_W-1:0]  val_r;
  logic [COL_W-1:0]   column_r;
  logic [ROW_W-1:0]   row_r;
  logic               finished_r;
  // Output register
  logic               out_valid_r;
  logic [BYTE_W-1:0]  pixel_r;
  logic               line_end_r;
  logic               image_end_r;
  logic               last_r;

  logic [COL_W-1:0]   bpl_eff;
  logic [ROW_W:0]     lines_eff;
  logic [COL_W-1:0]   room;
  logic [COUNT_W-1:0] cnt;
  logic               line_end_nxt;
  logic               image_end_nxt;
  logic [BYTE_W-1:0]  pixel_nxt;
  logic               out_free;

  // Treat zero lengths as one
  assign bpl_eff   = (bpl_r == '0) ? COL_W'(1) : bpl_r;
  assign lines_eff = (lines_r == '0) ? (ROW_W+1)'(1) : {1'b0, lines_r};

  // Clip the run at the end of the line
  assign room = (column_r >= bpl_eff) ? COL_W'(1) : (bpl_eff - column_r);
  assign cnt  = (room < {{(COL_W-COUNT_W){1'b0}}, run_len_r}) ? room[COUNT_W-1:0] : run_len_r;

  // Position flags of the pixel being emitted
  assign line_end_nxt  = ({1'b0, column_r} + (COL_W+1)'(1)) >= {1'b0, bpl_eff};
  assign image_end_nxt = line_end_nxt && (({1'b0, row_r} + (ROW_W+1)'(1)) >= lines_eff);
  assign pixel_nxt     = cmd.sel_input ? in_code_byte : val_r;

  assign out_free = !out_valid_r || !out_stall;

  // Report status to the controller
  always_comb begin
    stat.is_marker = (in_code_byte & pcxrle_pkg::MARK_BITS) == pcxrle_pkg::MARK_BITS;
    stat.cnt_zero  = (cnt == '0);
    stat.cnt_one   = (cnt == COUNT_W'(1));
    stat.rem_one   = (rem_r == COUNT_W'(1));
    stat.out_free  = out_free;
    stat.finished  = finished_r;
  end

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r   <= pcxrle_pkg::BPL_RESET;
      lines_r <= pcxrle_pkg::LINES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pcxrle_pkg::REG_BYTES_PER_LINE) begin
        bpl_r <= cfg_data[COL_W-1:0];
      end else if (cfg_index == pcxrle_pkg::REG_LINE_COUNT) begin
        lines_r <= cfg_data[ROW_W-1:0];
      end
    end
  end

  // Latch the run count, value and remaining pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= '0;
      rem_r     <= '0;
    end else begin
      if (cmd.load_run) begin
        run_len_r <= in_code_byte[COUNT_W-1:0] & pcxrle_pkg::COUNT_MASK;
      end else if (cmd.load_rem) begin
        run_len_r <= '0;
      end
      if (cmd.load_rem) begin
        rem_r <= cnt - COUNT_W'(1);
      end else if (cmd.dec_rem) begin
        rem_r <= rem_r - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rem) begin
      val_r <= in_code_byte;
    end
  end

  // Advance column and row on each emitted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      row_r      <= '0;
      finished_r <= 1'b0;
    end else if (cmd.emit) begin
      if (line_end_nxt) begin
        column_r <= '0;
        if (image_end_nxt) begin
          finished_r <= 1'b1;
        end else begin
          row_r <= row_r + ROW_W'(1);
        end
      end else begin
        column_r <= column_r + COL_W'(1);
      end
    end
  end

  // Load or drop the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_r     <= pixel_nxt;
      line_end_r  <= line_end_nxt;
      image_end_r <= image_end_nxt;
      last_r      <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = pixel_r;
  assign out_line_end    = line_end_r;
  assign out_image_end   = image_end_r;
  assign out_last        = last_r;

  // No pixel leaves a completed image or enters a full output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!finished_r && out_free))
    else $error("pixel emitted after image end or into a full register");

  // The image ends only at a line end
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && image_end_r) |-> line_end_r)
    else $error("image end without line end");

  // The last pixel of the image sets the finished flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && image_end_nxt) |=> finished_r)
    else $error("finished flag not set at image end");

endmodule
`default_nettype wire

@@ design/pcxrle_line_decoder_top.sv @@
// Top level of the PCX run-length line decoder.
`default_nettype none
// Decodes the run-length body of an 8-bit single-plane PCX image.
// Input channel: one encoded byte per word (in_valid / in_stall). A marker
// byte (top two bits set) carries a count in its low six bits; the next
// byte is then repeated that many times, clipped at the end of the line.
// Result channel: one pixel per word (out_valid / out_stall) with line_end,
// image_end and last (final pixel caused by the current input byte).
// Configuration: cfg_we / cfg_index / cfg_data; index 0 is bytes per line,
// index 1 the line count. Write only while the block is idle.
// Flow: a pixel is in the output register in the cycle after its byte is
// taken. Literal bytes pass at one per cycle while the output is not
// stalled. A run holds the input until its last pixel is loaded into the
// single output register; marker bytes and bytes after the image end are
// taken and give no pixel.
// Reset (rst_n low, synchronous) restores bytes per line 320, line count
// 200, and clears the position, run state and output register.
// When the receiver stalls, the output word holds and, before the image end,
// the input is stalled until the register drains.
module pcx_rle_line_decoder_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [pcxrle_pkg::BYTE_W-1:0]      in_code_byte,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [pcxrle_pkg::BYTE_W-1:0]      out_pixel_value,
  output logic                               out_line_end,
  output logic                               out_image_end,
  output logic                               out_last,
  input  wire                                cfg_we,
  input  wire  [pcxrle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [pcxrle_pkg::CFG_W-1:0]       cfg_data
);

  pcxrle_pkg::ctrl_cmd_t cmd;
  pcxrle_pkg::dp_stat_t  stat;

  // Sequence literals, markers and runs
  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Track position and hold the output word
  pcxrle_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_code_byte    (in_code_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .out_line_end    (out_line_end),
    .out_image_end   (out_image_end),
    .out_last        (out_last),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
`default_nettype wire
